>>> rtl/core/hcmb_pkg.sv
`default_nettype none

package hcmb_pkg;

  // memory geometry
  localparam int unsigned VRAM_DEPTH = 8192;
  localparam int unsigned WRAM_DEPTH = 8192;
  localparam int unsigned OAM_DEPTH  = 160;
  localparam int unsigned HRAM_DEPTH = 127;
  localparam int unsigned IO_DEPTH   = 128;

  localparam int unsigned VRAM_AW = 13;
  localparam int unsigned OAM_AW  = 8;
  localparam int unsigned IO_AW   = 7;
  localparam int unsigned HRAM_AW = 7;

  // request kinds carried on tuser
  typedef enum logic [2:0] {
    REQ_CPU_RD  = 3'd0,
    REQ_CPU_WR  = 3'd1,
    REQ_TICK    = 3'd2,
    REQ_PPU_VRD = 3'd3,
    REQ_PPU_VWR = 3'd4,
    REQ_PPU_ORD = 3'd5,
    REQ_PPU_OWR = 3'd6,
    REQ_UNDEF   = 3'd7
  } req_e;

  // where the read byte of a request comes from
  typedef enum logic [2:0] {
    RSEL_IMM  = 3'd0,
    RSEL_VRAM = 3'd1,
    RSEL_WRAM = 3'd2,
    RSEL_OAM  = 3'd3,
    RSEL_IO   = 3'd4,
    RSEL_HRAM = 3'd5
  } rsel_e;

  typedef struct packed {
    logic        active;
    logic [7:0]  page;
    logic [7:0]  count;
  } dma_t;

  // decoded request held between the input and result registers
  typedef struct packed {
    rsel_e       rsel;
    logic [7:0]  imm;
    logic        to_rdata;
    logic        to_oam;
    logic [7:0]  oam_idx;
    logic        cart_access;
    logic        cart_write;
    logic [15:0] cart_addr;
    logic [7:0]  cart_wdata;
    logic        dma_busy;
  } stage_t;

  // memory writes issued on acceptance
  typedef struct packed {
    logic        vram_we;
    logic        wram_we;
    logic        oam_we;
    logic        io_we;
    logic        hram_we;
    logic        ie_we;
    logic [12:0] idx;
    logic [7:0]  data;
  } wr_t;

  // clearing pass after reset
  typedef struct packed {
    logic        busy;
    logic [12:0] idx;
    logic [7:0]  io_data;
  } clr_t;

endpackage

`default_nettype wire

>>> rtl/core/hcmb_ram.sv
`default_nettype none

module hcmb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/hcmb_clear.sv
`default_nettype none

module hcmb_clear (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  output hcmb_pkg::clr_t     clr_o
);

  import hcmb_pkg::*;

  logic [VRAM_AW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;

  // power-up values of the i/o registers
  function automatic logic [7:0] io_reset(input logic [IO_AW-1:0] idx);
    logic [7:0] v;
    case (idx)
      7'h00:   v = 8'hCF;
      7'h02:   v = 8'h7E;
      7'h04:   v = 8'hAB;
      7'h07:   v = 8'hF8;
      7'h0F:   v = 8'hE1;
      7'h10:   v = 8'h80;
      7'h11:   v = 8'hBF;
      7'h12:   v = 8'hF3;
      7'h13:   v = 8'hFF;
      7'h14:   v = 8'hBF;
      7'h16:   v = 8'h3F;
      7'h18:   v = 8'hFF;
      7'h19:   v = 8'hBF;
      7'h1A:   v = 8'h7F;
      7'h1B:   v = 8'hFF;
      7'h1C:   v = 8'h9F;
      7'h1D:   v = 8'hFF;
      7'h1E:   v = 8'hBF;
      7'h20:   v = 8'hFF;
      7'h23:   v = 8'hBF;
      7'h24:   v = 8'h77;
      7'h25:   v = 8'hF3;
      7'h26:   v = 8'hF1;
      7'h40:   v = 8'h91;
      7'h41:   v = 8'h85;
      7'h46:   v = 8'hFF;
      7'h47:   v = 8'hFC;
      7'h48:   v = 8'hFF;
      7'h49:   v = 8'hFF;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (&cnt_q) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b1;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  assign clr_o.busy    = busy_q;
  assign clr_o.idx     = cnt_q;
  assign clr_o.io_data = io_reset(cnt_q[IO_AW-1:0]);

endmodule

`default_nettype wire

>>> rtl/core/hcmb_decode.sv
`default_nettype none

module hcmb_decode #(
  parameter int unsigned DMA_BYTES = 160
) (
  input  wire hcmb_pkg::req_e  req_i,
  input  wire logic [15:0]     addr_i,
  input  wire logic [7:0]      wdata_i,
  input  wire logic            vram_ok_i,
  input  wire logic            oam_ok_i,
  input  wire logic [7:0]      cart_rdata_i,
  input  wire logic [7:0]      ie_i,
  input  wire hcmb_pkg::dma_t  dma_i,
  output hcmb_pkg::stage_t     st_o,
  output hcmb_pkg::wr_t        wr_o,
  output hcmb_pkg::dma_t       dma_o,
  output logic [15:0]          raddr_o
);

  import hcmb_pkg::*;

  typedef enum logic [2:0] {
    RG_CART, RG_VRAM, RG_WRAM, RG_OAM, RG_NONE, RG_IO, RG_HRAM, RG_IE
  } region_e;

  typedef struct packed {
    rsel_e      rsel;
    logic [7:0] imm;
  } sel_t;

  localparam logic [15:0] ADDR_DIV  = 16'hFF04;
  localparam logic [15:0] ADDR_LY   = 16'hFF44;
  localparam logic [15:0] ADDR_DMA  = 16'hFF46;
  localparam logic [15:0] ADDR_IE   = 16'hFFFF;

  function automatic region_e region_of(input logic [15:0] a);
    region_e r;
    if (a < 16'h8000)                       r = RG_CART;
    else if (a < 16'hA000)                  r = RG_VRAM;
    else if (a < 16'hC000)                  r = RG_CART;
    else if (a < 16'hFE00)                  r = RG_WRAM;  // echo folds onto the low bits
    else if (a < 16'hFEA0)                  r = RG_OAM;
    else if (a < 16'hFF00)                  r = RG_NONE;
    else if (a < 16'hFF80)                  r = RG_IO;
    else if (a != ADDR_IE)                  r = RG_HRAM;
    else                                    r = RG_IE;
    return r;
  endfunction

  function automatic sel_t read_sel(input region_e r, input logic vok, input logic ook,
                                    input logic [7:0] cb, input logic [7:0] ie);
    sel_t s;
    s.rsel = RSEL_IMM;
    s.imm  = 8'h00;
    case (r)
      RG_CART: s.imm = cb;
      RG_VRAM: begin
        if (vok) s.rsel = RSEL_VRAM;
        else     s.imm  = 8'hFF;
      end
      RG_WRAM: s.rsel = RSEL_WRAM;
      RG_OAM: begin
        if (ook) s.rsel = RSEL_OAM;
        else     s.imm  = 8'hFF;
      end
      RG_IO:   s.rsel = RSEL_IO;
      RG_HRAM: s.rsel = RSEL_HRAM;
      RG_IE:   s.imm  = ie;
      default: s.imm  = 8'h00;
    endcase
    return s;
  endfunction

  logic [15:0] src;
  logic [15:0] eff;
  logic [7:0]  cnt_n;
  logic        hram;
  logic        lock;
  logic        oam_in;
  region_e     rg;
  sel_t        sel;

  assign src    = {dma_i.page, dma_i.count};
  assign eff    = (req_i == REQ_TICK) ? src : addr_i;
  assign rg     = region_of(eff);
  assign sel    = read_sel(rg, vram_ok_i, oam_ok_i, cart_rdata_i, ie_i);
  assign cnt_n  = dma_i.count + 8'd1;
  assign hram   = (addr_i[15:7] == 9'h1FF) && (addr_i != ADDR_IE);
  assign lock   = dma_i.active && !hram;
  assign oam_in = addr_i[7:0] < 8'(OAM_DEPTH);
  assign raddr_o = eff;

  always_comb begin
    st_o          = '0;
    st_o.rsel     = RSEL_IMM;
    st_o.oam_idx  = dma_i.count;
    wr_o          = '0;
    wr_o.idx      = addr_i[12:0];
    wr_o.data     = wdata_i;
    dma_o         = dma_i;

    case (req_i)
      REQ_CPU_RD: begin
        st_o.to_rdata = 1'b1;
        if (lock) begin
          st_o.imm = 8'hFF;
        end else begin
          st_o.rsel = sel.rsel;
          st_o.imm  = sel.imm;
          if (rg == RG_CART) begin
            st_o.cart_access = 1'b1;
            st_o.cart_addr   = addr_i;
          end
        end
      end
      REQ_CPU_WR: begin
        if (!lock) begin
          case (rg)
            RG_CART: begin
              st_o.cart_access = 1'b1;
              st_o.cart_write  = 1'b1;
              st_o.cart_addr   = addr_i;
              st_o.cart_wdata  = wdata_i;
            end
            RG_VRAM: wr_o.vram_we = vram_ok_i;
            RG_WRAM: wr_o.wram_we = 1'b1;
            RG_OAM:  wr_o.oam_we  = oam_ok_i;
            RG_IO: begin
              // div clears on any write, ly is read-only, ff46 kicks off dma
              wr_o.io_we = (addr_i != ADDR_LY);
              if (addr_i == ADDR_DIV) begin
                wr_o.data = 8'h00;
              end
              if (addr_i == ADDR_DMA) begin
                dma_o.active   = 1'b1;
                dma_o.page     = wdata_i;
                dma_o.count    = 8'h00;
                st_o.cart_addr = {wdata_i, 8'h00};
              end
            end
            RG_HRAM: wr_o.hram_we = 1'b1;
            RG_IE:   wr_o.ie_we   = 1'b1;
            default: wr_o.io_we   = 1'b0;
          endcase
        end
      end
      REQ_TICK: begin
        if (dma_i.active) begin
          st_o.rsel   = sel.rsel;
          st_o.imm    = sel.imm;
          st_o.to_oam = 1'b1;
          dma_o.count = cnt_n;
          if (cnt_n >= 8'(DMA_BYTES)) begin
            dma_o.active = 1'b0;
          end else begin
            st_o.cart_addr = {dma_i.page, cnt_n};
          end
        end
      end
      REQ_PPU_VRD: begin
        st_o.to_rdata = 1'b1;
        st_o.rsel     = RSEL_VRAM;
      end
      REQ_PPU_VWR: wr_o.vram_we = 1'b1;
      REQ_PPU_ORD: begin
        st_o.to_rdata = 1'b1;
        if (oam_in) st_o.rsel = RSEL_OAM;
        else        st_o.imm  = 8'hFF;
      end
      REQ_PPU_OWR: wr_o.oam_we = oam_in;
      default: st_o.to_rdata = 1'b0;
    endcase

    st_o.dma_busy = dma_o.active;
  end

endmodule

`default_nettype wire

>>> rtl/core/handheld_console_memory_bus.sv
// channel   | dir | tdata (low bit up)                                      | tuser
// s_axis    | in  | addr[15:0] wdata[23:16] vram_ok[24] oam_ok[25]          | req_type[2:0]
//           |     | cart_rdata[33:26], zero pad [39:34]                     |
// m_axis    | out | rdata[7:0] cart_access[8] cart_write[9] cart_addr[25:10] | -
//           |     | cart_wdata[33:26] dma_busy[34], zero pad [39:35]        |
//
// a request is taken every cycle unless an output stall or a dma copy holds the input; an active
// dma tick blocks the next request until its source byte comes back from the memory read register
// and is written into oam through oam's single write port
// a result passes the memory read register, then the result register, before it leaves
// after reset a clearing pass over 8192 addresses (the depth of the largest ram) loads the
// memories with zeros and the i/o power-up values; no request is taken meanwhile
// an output stall backs up into the input register and then lowers s_axis_tready_o
`default_nettype none

module handheld_console_memory_bus #(
  parameter int unsigned DMA_BYTES = 160
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request side
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,   // addr, wdata, vram_ok, oam_ok, cart_rdata
  input  wire logic [2:0]  s_axis_tuser_i,   // req_type
  // result side
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o    // rdata, cart_access, cart_write,
                                             // cart_addr, cart_wdata, dma_busy
);

  import hcmb_pkg::*;

  typedef struct packed {
    logic [7:0]  rdata;
    logic        cart_access;
    logic        cart_write;
    logic [15:0] cart_addr;
    logic [7:0]  cart_wdata;
    logic        dma_busy;
  } res_t;

  // request fields
  req_e        req;
  logic [15:0] addr;
  logic [7:0]  wdata;
  logic        vram_ok;
  logic        oam_ok;
  logic [7:0]  cart_rdata;

  assign req        = req_e'(s_axis_tuser_i);
  assign addr       = s_axis_tdata_i[15:0];
  assign wdata      = s_axis_tdata_i[23:16];
  assign vram_ok    = s_axis_tdata_i[24];
  assign oam_ok     = s_axis_tdata_i[25];
  assign cart_rdata = s_axis_tdata_i[33:26];

  // architectural state kept in flops
  dma_t        dma_q;
  logic [7:0]  ie_q;

  // pipeline
  logic        a_valid_q, a_valid_d;
  stage_t      a_q;
  logic        pend_q;
  logic        o_valid_q, o_valid_d;
  res_t        o_q;

  logic        accept;
  logic        a_adv;
  stage_t      st;
  wr_t         wr;
  dma_t        dma_d;
  logic [15:0] raddr;
  clr_t        clr;
  logic [7:0]  byte_rd;

  logic [7:0]  vram_rd, wram_rd, oam_rd, io_rd, hram_rd;

  hcmb_clear u_clear (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_o  (clr)
  );

  hcmb_decode #(
    .DMA_BYTES (DMA_BYTES)
  ) u_decode (
    .req_i        (req),
    .addr_i       (addr),
    .wdata_i      (wdata),
    .vram_ok_i    (vram_ok),
    .oam_ok_i     (oam_ok),
    .cart_rdata_i (cart_rdata),
    .ie_i         (ie_q),
    .dma_i        (dma_q),
    .st_o         (st),
    .wr_o         (wr),
    .dma_o        (dma_d),
    .raddr_o      (raddr)
  );

  // handshake: input stage frees up when the result register can take its item
  assign a_adv           = !o_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !clr.busy && !pend_q && (!a_valid_q || a_adv);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // memories; plain writes land on the accept edge, reads are issued on it too
  logic                vram_we, wram_we, oam_we, io_we, hram_we;
  logic [VRAM_AW-1:0]  vram_wa;
  logic [OAM_AW-1:0]   oam_wa;
  logic [IO_AW-1:0]    io_wa;
  logic [HRAM_AW-1:0]  hram_wa;
  logic [7:0]          vram_wd, oam_wd, io_wd, hram_wd;

  always_comb begin
    if (clr.busy) begin
      vram_we = 1'b1;
      wram_we = 1'b1;
      oam_we  = clr.idx < 13'(OAM_DEPTH);
      io_we   = clr.idx < 13'(IO_DEPTH);
      hram_we = clr.idx < 13'(HRAM_DEPTH);
      vram_wa = clr.idx;
      oam_wa  = clr.idx[OAM_AW-1:0];
      io_wa   = clr.idx[IO_AW-1:0];
      hram_wa = clr.idx[HRAM_AW-1:0];
      vram_wd = 8'h00;
      oam_wd  = 8'h00;
      io_wd   = clr.io_data;
      hram_wd = 8'h00;
    end else begin
      vram_we = accept && wr.vram_we;
      wram_we = accept && wr.wram_we;
      io_we   = accept && wr.io_we;
      hram_we = accept && wr.hram_we;
      vram_wa = wr.idx;
      io_wa   = wr.idx[IO_AW-1:0];
      hram_wa = wr.idx[HRAM_AW-1:0];
      vram_wd = wr.data;
      io_wd   = wr.data;
      hram_wd = wr.data;
      if (pend_q) begin
        // dma tick: source byte is back, copy it into oam
        oam_we = 1'b1;
        oam_wa = a_q.oam_idx;
        oam_wd = byte_rd;
      end else begin
        oam_we = accept && wr.oam_we;
        oam_wa = wr.idx[OAM_AW-1:0];
        oam_wd = wr.data;
      end
    end
  end

  hcmb_ram #(.WIDTH(8), .DEPTH(VRAM_DEPTH)) u_vram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .waddr_i (vram_wa),
    .wdata_i (vram_wd),
    .re_i    (accept),
    .raddr_i (raddr[VRAM_AW-1:0]),
    .rdata_o (vram_rd)
  );

  hcmb_ram #(.WIDTH(8), .DEPTH(WRAM_DEPTH)) u_wram (
    .clk_i   (clk_i),
    .we_i    (wram_we),
    .waddr_i (vram_wa),
    .wdata_i (vram_wd),
    .re_i    (accept),
    .raddr_i (raddr[VRAM_AW-1:0]),
    .rdata_o (wram_rd)
  );

  hcmb_ram #(.WIDTH(8), .DEPTH(OAM_DEPTH)) u_oam (
    .clk_i   (clk_i),
    .we_i    (oam_we),
    .waddr_i (oam_wa),
    .wdata_i (oam_wd),
    .re_i    (accept),
    .raddr_i (raddr[OAM_AW-1:0]),
    .rdata_o (oam_rd)
  );

  hcmb_ram #(.WIDTH(8), .DEPTH(IO_DEPTH)) u_io (
    .clk_i   (clk_i),
    .we_i    (io_we),
    .waddr_i (io_wa),
    .wdata_i (io_wd),
    .re_i    (accept),
    .raddr_i (raddr[IO_AW-1:0]),
    .rdata_o (io_rd)
  );

  hcmb_ram #(.WIDTH(8), .DEPTH(HRAM_DEPTH)) u_hram (
    .clk_i   (clk_i),
    .we_i    (hram_we),
    .waddr_i (hram_wa),
    .wdata_i (hram_wd),
    .re_i    (accept),
    .raddr_i (raddr[HRAM_AW-1:0]),
    .rdata_o (hram_rd)
  );

  // pick the byte of the request in the input stage
  always_comb begin
    case (a_q.rsel)
      RSEL_VRAM: byte_rd = vram_rd;
      RSEL_WRAM: byte_rd = wram_rd;
      RSEL_OAM:  byte_rd = oam_rd;
      RSEL_IO:   byte_rd = io_rd;
      RSEL_HRAM: byte_rd = hram_rd;
      default:   byte_rd = a_q.imm;
    endcase
  end

  always_comb begin
    a_valid_d = a_valid_q;
    if (accept) begin
      a_valid_d = 1'b1;
    end else if (a_adv) begin
      a_valid_d = 1'b0;
    end
    o_valid_d = o_valid_q;
    if (a_valid_q && a_adv) begin
      o_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      o_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
      pend_q    <= 1'b0;
      dma_q     <= '0;
      ie_q      <= 8'h00;
    end else begin
      a_valid_q <= a_valid_d;
      o_valid_q <= o_valid_d;
      pend_q    <= accept && st.to_oam;
      if (accept) begin
        dma_q <= dma_d;
        if (wr.ie_we) begin
          ie_q <= wr.data;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q <= st;
    end
    if (a_valid_q && a_adv) begin
      o_q.rdata       <= a_q.to_rdata ? byte_rd : 8'h00;
      o_q.cart_access <= a_q.cart_access;
      o_q.cart_write  <= a_q.cart_write;
      o_q.cart_addr   <= a_q.cart_addr;
      o_q.cart_wdata  <= a_q.cart_wdata;
      o_q.dma_busy    <= a_q.dma_busy;
    end
  end

  assign m_axis_tvalid_o = o_valid_q;
  assign m_axis_tdata_o  = {5'b0, o_q.dma_busy, o_q.cart_wdata, o_q.cart_addr,
                            o_q.cart_write, o_q.cart_access, o_q.rdata};

  // no request slips in while memories are being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni) clr.busy |-> !accept)
    else $error("request taken during clearing pass");

  // a pending oam copy always has its tick sitting in the input stage
  assert property (@(posedge clk_i) disable iff (!rst_ni) pend_q |-> a_valid_q && a_q.to_oam)
    else $error("oam copy without a tick in the input stage");

  // an active transfer never runs past its length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dma_q.active |-> dma_q.count < 8'(DMA_BYTES))
    else $error("dma count beyond transfer length");

  // a tick with no transfer running leaves dma idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req == REQ_TICK) && !dma_q.active |=> !dma_q.active)
    else $error("idle tick started dma");

endmodule

`default_nettype wire

>>> sim/tb_handheld_console_memory_bus.sv
`default_nettype none

module tb_handheld_console_memory_bus;
  import hcmb_pkg::*;

  localparam int unsigned DMA_LEN     = 160;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned MAX_GAP     = 17;

  // i/o registers with side effects or power-up values worth probing
  localparam logic [15:0] ADDR_JOYP = 16'hFF00;
  localparam logic [15:0] ADDR_DIV  = 16'hFF04;
  localparam logic [15:0] ADDR_IF   = 16'hFF0F;
  localparam logic [15:0] ADDR_LCDC = 16'hFF40;
  localparam logic [15:0] ADDR_STAT = 16'hFF41;
  localparam logic [15:0] ADDR_LY   = 16'hFF44;
  localparam logic [15:0] ADDR_DMA  = 16'hFF46;
  localparam logic [15:0] ADDR_IE   = 16'hFFFF;

  // one bus request as it travels on the input stream
  typedef struct packed {
    req_e        kind;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        vram_ok;
    logic        oam_ok;
    logic [7:0]  cart_rdata;
  } bus_req_t;

  // one bus response as it leaves on the output stream
  typedef struct packed {
    logic [7:0]  rdata;
    logic        cart_access;
    logic        cart_write;
    logic [15:0] cart_addr;
    logic [7:0]  cart_wdata;
    logic        dma_busy;
  } bus_rsp_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i;   // addr, wdata, vram_ok, oam_ok, cart_rdata, zero pad
  logic [2:0]  s_axis_tuser_i;   // req_type
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;   // rdata, cart_access, cart_write, cart_addr, cart_wdata,
                                 // dma_busy, zero pad

  handheld_console_memory_bus #(
    .DMA_BYTES(DMA_LEN)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // shadow copy of every store of the bus, updated as requests are accepted
  logic [7:0] shadow_vram [VRAM_DEPTH];
  logic [7:0] shadow_wram [WRAM_DEPTH];
  logic [7:0] shadow_oam  [OAM_DEPTH];
  logic [7:0] shadow_hram [HRAM_DEPTH];
  logic [7:0] shadow_io   [IO_DEPTH];
  logic [7:0] shadow_ie;
  logic       shadow_dma_active;
  logic [7:0] shadow_dma_page;
  logic [7:0] shadow_dma_count;

  bus_rsp_t awaited_responses [$];
  int unsigned failures;
  int unsigned cycle_count;

  // flow control: per-request waits, gap-free stretches and the long sink hold-off
  bit source_steady;
  bit sink_steady;
  int sink_stall_left;
  int sink_hold_cycles;

  // ---------------------------------------------------------------------------
  // clock, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // prediction of the bus
  // ---------------------------------------------------------------------------
  task automatic shadow_reset();
    for (int i = 0; i < VRAM_DEPTH; i++) shadow_vram[i] = 8'h00;
    for (int i = 0; i < WRAM_DEPTH; i++) shadow_wram[i] = 8'h00;
    for (int i = 0; i < OAM_DEPTH; i++) shadow_oam[i] = 8'h00;
    for (int i = 0; i < HRAM_DEPTH; i++) shadow_hram[i] = 8'h00;
    for (int i = 0; i < IO_DEPTH; i++) shadow_io[i] = 8'h00;
    // power-up contents of the i/o page
    shadow_io[7'h00] = 8'hCF; shadow_io[7'h02] = 8'h7E; shadow_io[7'h04] = 8'hAB;
    shadow_io[7'h07] = 8'hF8; shadow_io[7'h0F] = 8'hE1;
    shadow_io[7'h10] = 8'h80; shadow_io[7'h11] = 8'hBF; shadow_io[7'h12] = 8'hF3;
    shadow_io[7'h13] = 8'hFF; shadow_io[7'h14] = 8'hBF; shadow_io[7'h16] = 8'h3F;
    shadow_io[7'h18] = 8'hFF; shadow_io[7'h19] = 8'hBF; shadow_io[7'h1A] = 8'h7F;
    shadow_io[7'h1B] = 8'hFF; shadow_io[7'h1C] = 8'h9F; shadow_io[7'h1D] = 8'hFF;
    shadow_io[7'h1E] = 8'hBF; shadow_io[7'h20] = 8'hFF; shadow_io[7'h23] = 8'hBF;
    shadow_io[7'h24] = 8'h77; shadow_io[7'h25] = 8'hF3; shadow_io[7'h26] = 8'hF1;
    shadow_io[7'h40] = 8'h91; shadow_io[7'h41] = 8'h85; shadow_io[7'h46] = 8'hFF;
    shadow_io[7'h47] = 8'hFC; shadow_io[7'h48] = 8'hFF; shadow_io[7'h49] = 8'hFF;
    shadow_ie         = 8'h00;
    shadow_dma_active = 1'b0;
    shadow_dma_page   = 8'h00;
    shadow_dma_count  = 8'h00;
  endtask

  function automatic logic is_cart(input logic [15:0] a);
    return (a < 16'h8000) || (a >= 16'hA000 && a < 16'hC000);
  endfunction

  function automatic logic [15:0] dma_source();
    return {shadow_dma_page, 8'h00} + {8'h00, shadow_dma_count};
  endfunction

  // cpu view of a read, ignoring the dma lock; regions below fe00 that are
  // not cartridge all sit on 8 KiB boundaries, so the low 13 bits index them
  function automatic logic [7:0] cpu_view_read(input logic [15:0] a, input logic [7:0] cart_byte,
                                               input logic vok, input logic ook);
    if (is_cart(a)) return cart_byte;
    if (a < 16'hA000) return vok ? shadow_vram[a[12:0]] : 8'hFF;
    if (a < 16'hFE00) return shadow_wram[a[12:0]];   // wram and its echo
    if (a < 16'hFEA0) return ook ? shadow_oam[a[7:0]] : 8'hFF;
    if (a < 16'hFF00) return 8'h00;                  // unusable zone
    if (a < 16'hFF80) return shadow_io[a[6:0]];
    if (a < 16'hFFFF) return shadow_hram[a[6:0]];
    return shadow_ie;
  endfunction

  function automatic void cpu_view_write(input logic [15:0] a, input logic [7:0] v,
                                         input logic vok, input logic ook);
    if (is_cart(a)) return;
    if (a < 16'hA000) begin
      if (vok) shadow_vram[a[12:0]] = v;
    end else if (a < 16'hFE00) begin
      shadow_wram[a[12:0]] = v;
    end else if (a < 16'hFEA0) begin
      if (ook) shadow_oam[a[7:0]] = v;
    end else if (a < 16'hFF00) begin
      // unusable zone drops writes
    end else if (a < 16'hFF80) begin
      if (a == ADDR_DIV) begin
        shadow_io[a[6:0]] = 8'h00;
      end else if (a != ADDR_LY) begin
        shadow_io[a[6:0]] = v;
        if (a == ADDR_DMA) begin
          shadow_dma_page   = v;
          shadow_dma_count  = 8'h00;
          shadow_dma_active = 1'b1;
        end
      end
    end else if (a < 16'hFFFF) begin
      shadow_hram[a[6:0]] = v;
    end else begin
      shadow_ie = v;
    end
  endfunction

  // response of the bus to one request, advancing the shadow state
  function automatic bus_rsp_t bus_access_response(input bus_req_t r);
    bus_rsp_t rsp;
    logic     locked;
    rsp    = '0;
    // during dma the cpu reaches hram only
    locked = shadow_dma_active && !(r.addr >= 16'hFF80 && r.addr <= 16'hFFFE);
    case (r.kind)
      REQ_CPU_RD: begin
        if (locked) begin
          rsp.rdata = 8'hFF;
        end else begin
          if (is_cart(r.addr)) begin
            rsp.cart_access = 1'b1;
            rsp.cart_addr   = r.addr;
          end
          rsp.rdata = cpu_view_read(r.addr, r.cart_rdata, r.vram_ok, r.oam_ok);
        end
      end
      REQ_CPU_WR: begin
        if (!locked && is_cart(r.addr)) begin
          rsp.cart_access = 1'b1;
          rsp.cart_write  = 1'b1;
          rsp.cart_addr   = r.addr;
          rsp.cart_wdata  = r.wdata;
        end else if (!locked) begin
          cpu_view_write(r.addr, r.wdata, r.vram_ok, r.oam_ok);
          if (r.addr == ADDR_DMA && shadow_dma_active) rsp.cart_addr = dma_source();
        end
      end
      REQ_TICK: begin
        if (shadow_dma_active) begin
          shadow_oam[shadow_dma_count] =
            cpu_view_read(dma_source(), r.cart_rdata, r.vram_ok, r.oam_ok);
          shadow_dma_count++;
          if (shadow_dma_count >= DMA_LEN) shadow_dma_active = 1'b0;
          else rsp.cart_addr = dma_source();
        end
      end
      REQ_PPU_VRD: rsp.rdata = shadow_vram[r.addr[12:0]];
      REQ_PPU_VWR: shadow_vram[r.addr[12:0]] = r.wdata;
      REQ_PPU_ORD: rsp.rdata = (r.addr[7:0] < OAM_DEPTH) ? shadow_oam[r.addr[7:0]] : 8'hFF;
      REQ_PPU_OWR: begin
        if (r.addr[7:0] < OAM_DEPTH) shadow_oam[r.addr[7:0]] = r.wdata;
      end
      default: begin
        // undefined request does nothing
      end
    endcase
    rsp.dma_busy = shadow_dma_active;
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // request source and result sink
  // ---------------------------------------------------------------------------
  function automatic int draw_gap(input bit steady);
    if (steady) return 0;
    return ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(0, MAX_GAP));
  endfunction

  // offers one request after a random wait and records its response on acceptance
  task automatic send_request(input req_e kind, input logic [15:0] addr,
                              input logic [7:0] wdata = 8'h00, input logic vram_ok = 1'b1,
                              input logic oam_ok = 1'b1, input logic [7:0] cart_rdata = 8'h00);
    bus_req_t r;
    int       gap;
    r   = '{kind, addr, wdata, vram_ok, oam_ok, cart_rdata};
    gap = draw_gap(source_steady);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= r.kind;
    s_axis_tdata_i  <= {6'b0, r.cart_rdata, r.oam_ok, r.vram_ok, r.wdata, r.addr};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    awaited_responses.push_back(bus_access_response(r));
  endtask

  // source goes quiet until every response is back
  task automatic wait_for_results();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk_i);
  endtask

  // sink: a long hold-off when asked, otherwise a random wait per response
  initial begin
    forever begin
      @(negedge clk_i);
      if (sink_hold_cycles > 0) begin
        m_axis_tready_i <= 1'b0;
        sink_hold_cycles--;
      end else if (sink_stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        sink_stall_left--;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  function automatic string fmt_rsp(input bus_rsp_t x);
    return $sformatf("rd=%02h acc=%0b wr=%0b ca=%04h cwd=%02h busy=%0b",
                     x.rdata, x.cart_access, x.cart_write, x.cart_addr, x.cart_wdata,
                     x.dma_busy);
  endfunction

  // compare every response with the oldest awaited one
  always @(posedge clk_i) begin
    bus_rsp_t got;
    bus_rsp_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.rdata       = m_axis_tdata_o[7:0];
      got.cart_access = m_axis_tdata_o[8];
      got.cart_write  = m_axis_tdata_o[9];
      got.cart_addr   = m_axis_tdata_o[25:10];
      got.cart_wdata  = m_axis_tdata_o[33:26];
      got.dma_busy    = m_axis_tdata_o[34];
      if (awaited_responses.size() == 0) begin
        failures++;
        if (failures <= 10) $display("response with none awaited: %s", fmt_rsp(got));
      end else begin
        want = awaited_responses.pop_front();
        if (got !== want) begin
          failures++;
          if (failures <= 10)
            $display("response mismatch\n  expected %s\n  actual   %s",
                     fmt_rsp(want), fmt_rsp(got));
        end
      end
      sink_stall_left = draw_gap(sink_steady);
    end
  end

  // ---------------------------------------------------------------------------
  // random requests
  // ---------------------------------------------------------------------------
  // address inside a random region, mostly near its start so reads find
  // earlier writes, sometimes anywhere in the 16-bit space
  function automatic logic [15:0] pick_addr();
    logic [15:0] base;
    logic [15:0] span;
    logic [15:0] off;
    case ($urandom_range(0, 10))
      0:       begin base = 16'h0000; span = 16'h8000; end
      1:       begin base = 16'h8000; span = 16'h2000; end
      2:       begin base = 16'hA000; span = 16'h2000; end
      3:       begin base = 16'hC000; span = 16'h2000; end
      4:       begin base = 16'hE000; span = 16'h1E00; end
      5:       begin base = 16'hFE00; span = 16'h00A0; end
      6:       begin base = 16'hFEA0; span = 16'h0060; end
      7:       begin base = 16'hFF00; span = 16'h0080; end
      8:       begin base = 16'hFF80; span = 16'h007F; end
      9:       begin base = ADDR_IE;  span = 16'h0001; end
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
    if ($urandom_range(0, 3) == 0) off = 16'($urandom_range(0, span - 1));
    else off = 16'($urandom_range(0, 15) % span);
    return base + off;
  endfunction

  task automatic send_random();
    req_e        kind;
    logic [15:0] a;
    int          pick;
    pick = $urandom_range(0, 99);
    // while dma runs, half of the traffic keeps it moving
    if (shadow_dma_active && pick < 50) begin
      kind = REQ_TICK;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 30) kind = REQ_CPU_RD;
      else if (pick < 60) kind = REQ_CPU_WR;
      else if (pick < 65) kind = REQ_TICK;
      else if (pick < 72) kind = REQ_PPU_VRD;
      else if (pick < 79) kind = REQ_PPU_VWR;
      else if (pick < 86) kind = REQ_PPU_ORD;
      else if (pick < 97) kind = REQ_PPU_OWR;
      else kind = REQ_UNDEF;
    end
    a = pick_addr();
    if (kind == REQ_CPU_WR && $urandom_range(0, 149) == 0) begin
      a = ADDR_DMA;
    end else if ((kind == REQ_CPU_WR || kind == REQ_CPU_RD) && $urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 5))
        0:       a = ADDR_JOYP;
        1:       a = ADDR_DIV;
        2:       a = ADDR_LY;
        3:       a = ADDR_IF;
        4:       a = ADDR_LCDC;
        default: a = ADDR_STAT;
      endcase
    end
    send_request(kind, a, 8'($urandom), $urandom_range(0, 3) != 0,
                 $urandom_range(0, 3) != 0, 8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // region decode, gating, i/o side effects and the ppu ports, one by one
  task automatic test_directed();
    send_request(REQ_CPU_RD, ADDR_JOYP);                    // power-up 0xcf
    send_request(REQ_CPU_RD, ADDR_IF);                      // power-up 0xe1
    send_request(REQ_CPU_RD, ADDR_LCDC);                    // power-up 0x91
    send_request(REQ_CPU_RD, ADDR_STAT);                    // power-up 0x85
    send_request(REQ_CPU_WR, ADDR_DIV, 8'h5A);              // div write clears it
    send_request(REQ_CPU_RD, ADDR_DIV);
    send_request(REQ_CPU_WR, ADDR_LY, 8'h33);               // ly is read only
    send_request(REQ_CPU_RD, ADDR_LY);
    send_request(REQ_CPU_WR, 16'hC000, 8'hAA);
    send_request(REQ_CPU_RD, 16'hE000);                     // echo of c000
    send_request(REQ_CPU_WR, 16'hFDFF, 8'h11);              // top of echo
    send_request(REQ_CPU_RD, 16'hDDFF);
    send_request(REQ_CPU_WR, 16'h8000, 8'hEE, 1'b0);        // vram write dropped
    send_request(REQ_CPU_RD, 16'h8000, 8'h00, 1'b1);
    send_request(REQ_CPU_RD, 16'h9FFF, 8'h00, 1'b0);        // gated vram read
    send_request(REQ_CPU_WR, 16'hFE00, 8'h77, 1'b1, 1'b1);
    send_request(REQ_CPU_RD, 16'hFE00, 8'h00, 1'b1, 1'b0);  // gated oam read
    send_request(REQ_CPU_RD, 16'hFE00, 8'h00, 1'b1, 1'b1);
    send_request(REQ_CPU_RD, 16'hFEA0);                     // unusable zone
    send_request(REQ_CPU_RD, 16'h0000, 8'h00, 1'b1, 1'b1, 8'hFF);
    send_request(REQ_CPU_WR, 16'hBFFF, 8'hFF);
    send_request(REQ_CPU_WR, ADDR_IE, 8'hFF);
    send_request(REQ_CPU_RD, ADDR_IE);
    send_request(REQ_CPU_WR, 16'hFFFE, 8'h5C);
    send_request(REQ_CPU_RD, 16'hFFFE);
    send_request(REQ_PPU_VWR, 16'h9FFF, 8'hC3);
    send_request(REQ_PPU_VRD, 16'hFFFF);                    // same vram cell, low 13 bits
    send_request(REQ_PPU_OWR, 16'hFE9F, 8'h3C);
    send_request(REQ_PPU_ORD, 16'hFEA0);                    // oam index past the end
    send_request(REQ_UNDEF, 16'hFFFF, 8'hFF);
    send_request(REQ_TICK, 16'h0000);                       // tick with no dma
  endtask

  // one full oam dma from the given page, with the cpu lock probed at its start
  task automatic test_dma_transfer(input logic [7:0] page);
    logic [15:0] a;
    // let any transfer already under way finish first
    while (shadow_dma_active) send_request(REQ_TICK, 16'h0000, 8'h00, 1'b1, 1'b1, 8'($urandom));
    if (page != 8'hFF) begin
      for (int i = 0; i < 12; i++) begin
        a = {page, 8'($urandom_range(0, DMA_LEN - 1))};
        send_request(REQ_CPU_WR, a, 8'($urandom));
      end
    end
    send_request(REQ_CPU_WR, ADDR_DMA, page);
    send_request(REQ_CPU_RD, 16'hC000);                     // locked: reads 0xff
    send_request(REQ_CPU_WR, 16'hC000, 8'h42);              // locked: dropped
    send_request(REQ_CPU_RD, 16'h0000, 8'h00, 1'b1, 1'b1, 8'h99);
    send_request(REQ_CPU_WR, ADDR_DMA, 8'h00);              // no restart
    send_request(REQ_CPU_WR, 16'hFF90, 8'h24);              // hram still open
    send_request(REQ_CPU_RD, 16'hFF90);
    send_request(REQ_CPU_RD, ADDR_IE);
    while (shadow_dma_active) begin
      if ($urandom_range(0, 9) < 7)
        send_request(REQ_TICK, 16'($urandom), 8'($urandom), $urandom_range(0, 3) != 0,
                     $urandom_range(0, 3) != 0, 8'($urandom));
      else send_random();
    end
    // read the copy back through both ports
    for (int i = 0; i < 10; i++)
      send_request(REQ_CPU_RD, 16'hFE00 + 16'($urandom_range(0, DMA_LEN - 1)));
    for (int i = 0; i < 4; i++)
      send_request(REQ_PPU_ORD, 16'hFE00 + 16'($urandom_range(0, DMA_LEN - 1)));
  endtask

  // random traffic with gap-free stretches on either side now and then
  task automatic test_random_traffic(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) begin
        source_steady = ($urandom_range(0, 3) == 0);
        sink_steady   = ($urandom_range(0, 3) == 0);
      end
      send_random();
    end
    source_steady = 1'b0;
    sink_steady   = 1'b0;
  endtask

  // sink holds off while the source keeps offering, so the bus fills and stalls;
  // then the source pauses until everything has drained
  task automatic test_backpressure();
    sink_hold_cycles = 80;
    source_steady    = 1'b1;
    for (int i = 0; i < 30; i++) send_random();
    source_steady = 1'b0;
    wait_for_results();
    for (int i = 0; i < 10; i++) send_random();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] first_page;
    logic [7:0] second_page;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = REQ_CPU_RD;
    source_steady   = 1'b0;
    sink_steady     = 1'b0;
    sink_stall_left = 0;
    sink_hold_cycles = 0;
    failures        = 0;
    cycle_count     = 0;
    shadow_reset();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // ram-backed source pages first, then cartridge, oam or i/o pages
    case ($urandom_range(0, 2))
      0:       first_page = 8'hC0 + 8'($urandom_range(0, 31));
      1:       first_page = 8'hE0 + 8'($urandom_range(0, 29));
      default: first_page = 8'h80 + 8'($urandom_range(0, 31));
    endcase
    case ($urandom_range(0, 3))
      0:       second_page = 8'($urandom_range(0, 8'h7F));
      1:       second_page = 8'hA0 + 8'($urandom_range(0, 31));
      2:       second_page = 8'hFE;
      default: second_page = 8'hFF;
    endcase

    test_directed();
    wait_for_results();
    test_dma_transfer(first_page);
    wait_for_results();
    test_random_traffic(150);
    wait_for_results();
    test_backpressure();
    wait_for_results();
    test_dma_transfer(second_page);
    test_random_traffic(100);
    wait_for_results();

    repeat (20) @(posedge clk_i);
    if (failures == 0 && awaited_responses.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
